FILE: hdl/sca_pkg.sv
// Shared types and constants for the size-class block allocator.
// Used by sca_class, sca_ctrl, sca_dp and size_class_block_allocator_core.
`default_nettype none
package sca_pkg;

  localparam int SIZE_W      = 38;
  localparam int HANDLE_W    = 10;
  localparam int BLOCK_ID_W  = 10;
  localparam int STATUS_W    = 3;
  localparam int CLASS_OUT_W = 5;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REUSED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOUBLE  = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic                load_req;   // capture the request fields
    logic                calc;       // latch class, read head and block info
    logic                check_ok;   // take class from block rank, read its head
    logic                push;       // link freed block on top of its list
    logic                take_head;  // hold head id, read its link
    logic                pop;        // unlink head block
    logic                issue_new;  // hand out the next fresh id
    logic                out_load;   // load the output register
    logic [STATUS_W-1:0] out_status;
    logic                out_id_en;
    logic                out_cls_en;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_type;
    logic size_zero;
    logic too_big;
    logic unknown;
    logic in_use;
    logic count_nz;
    logic pool_full;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/sca_class.sv
// Size to class decode: smallest rank whose block size covers the request.
// Depends on sca_pkg.
`default_nettype none
module sca_class
  import sca_pkg::*;
#(
  parameter int NUM_CLASSES     = 32,
  parameter int MIN_BLOCK_SHIFT = 6,
  localparam int CLS_W          = $clog2(NUM_CLASSES)
) (
  input  wire logic [SIZE_W-1:0] size,
  output logic      [CLS_W-1:0]  cls,
  output logic                   found
);

  logic [NUM_CLASSES-1:0] fit;
  logic [63:0]            size_wide;

  assign size_wide = {{(64-SIZE_W){1'b0}}, size};

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_fit
    assign fit[g] = (size_wide <= (64'd1 << (MIN_BLOCK_SHIFT + g)));
  end

  // fit is a thermometer code; pick its lowest set bit
  always_comb begin
    cls = '0;
    for (int r = NUM_CLASSES - 1; r >= 0; r--) begin
      if (fit[r]) cls = CLS_W'(r);
    end
    found = |fit;
  end

endmodule
`default_nettype wire

FILE: hdl/sca_dp.sv
// Allocator datapath: request registers, block and list memories, counters
// and the output register. Depends on sca_pkg and sca_class.
`default_nettype none
module sca_dp
  import sca_pkg::*;
#(
  parameter int NUM_CLASSES     = 32,
  parameter int MIN_BLOCK_SHIFT = 6,
  parameter int MAX_BLOCKS      = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output stat_t                       stat,
  input  wire logic                   req_type,
  input  wire logic [SIZE_W-1:0]      size,
  input  wire logic [HANDLE_W-1:0]    handle,
  output logic      [STATUS_W-1:0]    status,
  output logic      [BLOCK_ID_W-1:0]  block_id,
  output logic      [CLASS_OUT_W-1:0] size_class
);

  localparam int CLS_W = $clog2(NUM_CLASSES);
  localparam int ID_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int HW_W  = ID_W + HANDLE_W;

  logic              req_q;
  logic [SIZE_W-1:0] size_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CLS_W-1:0]  cls_q;
  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  issued;
  logic [CNT_W-1:0]  count [NUM_CLASSES];

  logic [CLS_W-1:0]  rank_mem [MAX_BLOCKS];
  logic [ID_W-1:0]   link_mem [MAX_BLOCKS];
  logic              use_mem  [MAX_BLOCKS];
  logic [ID_W-1:0]   head_mem [NUM_CLASSES];

  logic [CLS_W-1:0]  rank_rd;
  logic              use_rd;
  logic [ID_W-1:0]   head_rd;
  logic [ID_W-1:0]   link_rd;

  logic [CLS_W-1:0]  cls_calc;
  logic              cls_found;
  logic [HW_W-1:0]   handle_wide;
  logic [HW_W-1:0]   issued_wide;
  logic [ID_W-1:0]   handle_idx;
  logic [ID_W-1:0]   issued_idx;
  logic [HW_W-1:0]   id_wide;
  logic [CLS_W+CLASS_OUT_W-1:0] cls_wide;

  logic              use_we;
  logic [ID_W-1:0]   use_wa;
  logic              use_wd;
  logic              head_we;
  logic [ID_W-1:0]   head_wd;
  logic [CLS_W-1:0]  head_ra;

  sca_class #(
    .NUM_CLASSES     (NUM_CLASSES),
    .MIN_BLOCK_SHIFT (MIN_BLOCK_SHIFT)
  ) u_class (
    .size  (size_q),
    .cls   (cls_calc),
    .found (cls_found)
  );

  assign handle_wide = {{ID_W{1'b0}}, handle_q};
  assign issued_wide = HW_W'(issued);
  assign handle_idx  = handle_wide[ID_W-1:0];
  assign issued_idx  = issued_wide[ID_W-1:0];
  assign id_wide     = {{HANDLE_W{1'b0}}, id_q};
  assign cls_wide    = {{CLASS_OUT_W{1'b0}}, cls_q};

  assign stat.req_type  = req_q;
  assign stat.size_zero = (size_q == '0);
  assign stat.too_big   = !cls_found;
  assign stat.unknown   = (handle_wide >= issued_wide);
  assign stat.in_use    = use_rd;
  assign stat.count_nz  = (count[cls_q] != '0);
  assign stat.pool_full = (issued == CNT_W'(MAX_BLOCKS));

  // Write and read port selection
  always_comb begin
    use_we  = cmd.push | cmd.pop | cmd.issue_new;
    use_wa  = id_q;
    use_wd  = 1'b1;
    if (cmd.push) begin
      use_wa = handle_idx;
      use_wd = 1'b0;
    end else if (cmd.issue_new) begin
      use_wa = issued_idx;
    end
    head_we = cmd.push | cmd.pop;
    head_wd = cmd.push ? handle_idx : link_rd;
    head_ra = cmd.check_ok ? rank_rd : cls_calc;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q    <= req_type;
      size_q   <= size;
      handle_q <= handle;
    end
    if (cmd.calc) begin
      cls_q   <= cls_calc;
      rank_rd <= rank_mem[handle_idx];
      use_rd  <= use_mem[handle_idx];
    end
    if (cmd.check_ok) cls_q <= rank_rd;
    if (cmd.calc || cmd.check_ok) head_rd <= head_mem[head_ra];
    if (head_we) head_mem[cls_q] <= head_wd;
    if (cmd.take_head) begin
      id_q    <= head_rd;
      link_rd <= link_mem[head_rd];
    end
    if (cmd.issue_new) begin
      id_q                 <= issued_idx;
      rank_mem[issued_idx] <= cls_q;
    end
    if (cmd.push) link_mem[handle_idx] <= head_rd;
    if (use_we) use_mem[use_wa] <= use_wd;
    if (cmd.out_load) begin
      status     <= cmd.out_status;
      block_id   <= cmd.out_id_en ? id_wide[BLOCK_ID_W-1:0] : '0;
      size_class <= cmd.out_cls_en ? cls_wide[CLASS_OUT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) count[i] <= '0;
    end else begin
      if (cmd.issue_new) issued <= issued + 1'b1;
      if (cmd.push) count[cls_q] <= count[cls_q] + 1'b1;
      else if (cmd.pop) count[cls_q] <= count[cls_q] - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sca_ctrl.sv
// Allocator controller: sequences one transaction through the datapath and
// owns the input ready and output valid. Depends on sca_pkg.
`default_nettype none
module sca_ctrl
  import sca_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLASS  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_HEAD   = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]          state, state_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                res_id_en, res_id_en_next;
  logic                res_cls_en, res_cls_en_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    res_status_next = res_status;
    res_id_en_next  = res_id_en;
    res_cls_en_next = res_cls_en;
    cmd.out_status  = res_status;
    cmd.out_id_en   = res_id_en;
    cmd.out_cls_en  = res_cls_en;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.calc        = 1'b1;
        res_id_en_next  = 1'b0;
        res_cls_en_next = 1'b0;
        if (stat.req_type == REQ_FREE) begin
          state_next = S_CHECK;
        end else if (stat.size_zero) begin
          res_status_next = ST_ZERO;
          state_next      = S_RESULT;
        end else if (stat.too_big) begin
          res_status_next = ST_FULL;
          state_next      = S_RESULT;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_CHECK: begin
        if (stat.unknown) begin
          res_status_next = ST_UNKNOWN;
          state_next      = S_RESULT;
        end else if (!stat.in_use) begin
          res_status_next = ST_DOUBLE;
          state_next      = S_RESULT;
        end else begin
          cmd.check_ok = 1'b1;
          state_next   = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push        = 1'b1;
        res_status_next = ST_REUSED;
        res_cls_en_next = 1'b1;
        state_next      = S_RESULT;
      end
      S_HEAD: begin
        if (stat.count_nz) begin
          cmd.take_head = 1'b1;
          state_next    = S_POP;
        end else if (stat.pool_full) begin
          res_status_next = ST_FULL;
          state_next      = S_RESULT;
        end else begin
          cmd.issue_new   = 1'b1;
          res_status_next = ST_NEW;
          res_id_en_next  = 1'b1;
          res_cls_en_next = 1'b1;
          state_next      = S_RESULT;
        end
      end
      S_POP: begin
        cmd.pop         = 1'b1;
        res_status_next = ST_REUSED;
        res_id_en_next  = 1'b1;
        res_cls_en_next = 1'b1;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_id_en  <= res_id_en_next;
    res_cls_en <= res_cls_en_next;
  end

endmodule
`default_nettype wire

FILE: hdl/size_class_block_allocator_core.sv
// Power-of-two size-class block allocator, top level.
// Depends on sca_pkg, sca_ctrl and sca_dp.
//
// Input channel (in_valid/in_ready): req_type selects allocate or free;
// size is used on allocate, handle on free. Output channel
// (out_valid/out_ready) returns one transaction per request: status,
// block_id and size_class.
// Allocate maps the size to the smallest rank with a big enough block, pops
// the most recently freed block of that rank or issues a fresh id. Free
// pushes the block back on its rank's list. Zero size, pool full, unknown id
// and double free are reported in status with block_id and size_class zero.
// Errors found during size decode go from the class state to the result state;
// new blocks, pool full and errors found on the block check also pass the head
// or check state, and frees and reuses then a push or pop state. The next
// request is taken in the cycle after the result is loaded. The path is set
// by the registered memory reads (block info, head, then link) it walks.
// Reset empties all free lists and clears the issue counter; the block
// memories need no clearing, so the block is ready right after reset.
// A result waiting in the output register does not block the next request;
// a stalled receiver only holds the following result back.
`default_nettype none
module size_class_block_allocator_core
  import sca_pkg::*;
#(
  parameter int NUM_CLASSES     = 32,
  parameter int MIN_BLOCK_SHIFT = 6,
  parameter int MAX_BLOCKS      = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   req_type,
  input  wire logic [SIZE_W-1:0]      size,
  input  wire logic [HANDLE_W-1:0]    handle,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [STATUS_W-1:0]    status,
  output logic      [BLOCK_ID_W-1:0]  block_id,
  output logic      [CLASS_OUT_W-1:0] size_class
);

  cmd_t  cmd;
  stat_t stat;

  sca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sca_dp #(
    .NUM_CLASSES     (NUM_CLASSES),
    .MIN_BLOCK_SHIFT (MIN_BLOCK_SHIFT),
    .MAX_BLOCKS      (MAX_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .size       (size),
    .handle     (handle),
    .status     (status),
    .block_id   (block_id),
    .size_class (size_class)
  );

endmodule
`default_nettype wire

FILE: tb/tb_size_class_block_allocator_core.sv
// Self-checking testbench for size_class_block_allocator_core.
// Drives allocate and free requests through valid/ready; checks each result against a typed
// grant or a behavioral allocator kept in the bench. Depends on sca_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_size_class_block_allocator_core;
  import sca_pkg::*;

  localparam int NUM_CLASSES = 32;
  localparam int MIN_SHIFT   = 6;
  localparam int MAX_BLOCKS  = 1024;
  localparam int RANDOM_REQS = 580;

  typedef struct packed {
    logic                req;
    logic [SIZE_W-1:0]   sz;
    logic [HANDLE_W-1:0] hd;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    st;
    logic [BLOCK_ID_W-1:0]  id;
    logic [CLASS_OUT_W-1:0] cls;
  } grant_t;

  // Directed row: request, then whether the expected grant is typed in, then that grant.
  typedef struct packed {
    logic                   req;
    logic [SIZE_W-1:0]      sz;
    logic [HANDLE_W-1:0]    hd;
    logic                   typed;
    logic [STATUS_W-1:0]    st;
    logic [BLOCK_ID_W-1:0]  id;
    logic [CLASS_OUT_W-1:0] cls;
  } plan_row_t;

  localparam int PLAN_LEN = 23;
  plan_row_t plan [PLAN_LEN] = '{
    '{REQ_FREE,  38'd0,              10'd0,    1'b1, ST_UNKNOWN, 10'd0, 5'd0},
    '{REQ_ALLOC, 38'd0,              10'd0,    1'b1, ST_ZERO,    10'd0, 5'd0},
    '{REQ_ALLOC, 38'h3F_FFFF_FFFF,   10'd0,    1'b1, ST_FULL,    10'd0, 5'd0},
    '{REQ_ALLOC, 38'h20_0000_0001,   10'd0,    1'b1, ST_FULL,    10'd0, 5'd0},
    '{REQ_ALLOC, 38'd1,              10'd0,    1'b1, ST_NEW,     10'd0, 5'd0},
    '{REQ_ALLOC, 38'd64,             10'd0,    1'b1, ST_NEW,     10'd1, 5'd0},
    '{REQ_ALLOC, 38'd65,             10'd0,    1'b1, ST_NEW,     10'd2, 5'd1},
    '{REQ_ALLOC, 38'h20_0000_0000,   10'd0,    1'b1, ST_NEW,     10'd3, 5'd31},
    '{REQ_FREE,  38'd0,              10'd1,    1'b1, ST_REUSED,  10'd0, 5'd0},
    '{REQ_FREE,  38'd0,              10'd1,    1'b1, ST_DOUBLE,  10'd0, 5'd0},
    '{REQ_FREE,  38'd0,              10'd0,    1'b1, ST_REUSED,  10'd0, 5'd0},
    '{REQ_ALLOC, 38'd33,             10'd0,    1'b1, ST_REUSED,  10'd0, 5'd0},
    '{REQ_ALLOC, 38'd64,             10'd0,    1'b1, ST_REUSED,  10'd1, 5'd0},
    '{REQ_ALLOC, 38'd64,             10'd0,    1'b0, '0,         '0,    '0},
    '{REQ_FREE,  38'd0,              10'd3,    1'b1, ST_REUSED,  10'd0, 5'd31},
    '{REQ_ALLOC, 38'h10_0000_0001,   10'd0,    1'b1, ST_REUSED,  10'd3, 5'd31},
    '{REQ_FREE,  38'd0,              10'd1023, 1'b1, ST_UNKNOWN, 10'd0, 5'd0},
    '{REQ_FREE,  38'd0,              10'd5,    1'b1, ST_UNKNOWN, 10'd0, 5'd0},
    '{REQ_ALLOC, 38'd128,            10'd1023, 1'b1, ST_NEW,     10'd5, 5'd1},
    '{REQ_FREE,  38'h3F_FFFF_FFFF,   10'd2,    1'b1, ST_REUSED,  10'd0, 5'd1},
    '{REQ_FREE,  38'd0,              10'd5,    1'b1, ST_REUSED,  10'd0, 5'd1},
    '{REQ_ALLOC, 38'd100,            10'd0,    1'b0, '0,         '0,    '0},
    '{REQ_ALLOC, 38'd128,            10'd0,    1'b1, ST_REUSED,  10'd2, 5'd1}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   req_type = REQ_ALLOC;
  logic [SIZE_W-1:0]      size = '0;
  logic [HANDLE_W-1:0]    handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  logic [STATUS_W-1:0]    status;
  logic [BLOCK_ID_W-1:0]  block_id;
  logic [CLASS_OUT_W-1:0] size_class;

  // Allocator state as the bench sees it
  logic [CLASS_OUT_W-1:0] block_rank [MAX_BLOCKS];
  logic [HANDLE_W-1:0]    next_link  [MAX_BLOCKS];
  bit                     busy       [MAX_BLOCKS];
  logic [HANDLE_W-1:0]    list_top   [NUM_CLASSES];
  int unsigned            list_len   [NUM_CLASSES];
  int unsigned            issued = 0;
  logic [HANDLE_W-1:0]    live_q [$];

  grant_t grants_due [$];
  int     fails = 0;
  bit     calm = 1'b0;
  int     sink_hold = 0;

  size_class_block_allocator_core #(
    .NUM_CLASSES    (NUM_CLASSES),
    .MIN_BLOCK_SHIFT(MIN_SHIFT),
    .MAX_BLOCKS     (MAX_BLOCKS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .size      (size),
    .handle    (handle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .block_id  (block_id),
    .size_class(size_class)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one accepted request to the bench allocator and return its grant.
  function automatic grant_t predict_grant(request_t rq);
    grant_t              g;
    int                  rank;
    int                  idx;
    logic [HANDLE_W-1:0] id;
    g = '0;
    if (rq.req == REQ_ALLOC) begin
      rank = NUM_CLASSES;
      for (int r = NUM_CLASSES - 1; r >= 0; r--)
        if (64'(rq.sz) <= (64'd1 << (MIN_SHIFT + r))) rank = r;
      if (rq.sz == '0) begin
        g.st = ST_ZERO;
      end else if (rank == NUM_CLASSES) begin
        g.st = ST_FULL;
      end else if (list_len[rank] != 0) begin
        id = list_top[rank];
        list_top[rank] = next_link[id];
        list_len[rank]--;
        busy[id] = 1'b1;
        live_q.push_back(id);
        g.st  = ST_REUSED;
        g.id  = id;
        g.cls = CLASS_OUT_W'(rank);
      end else if (issued >= MAX_BLOCKS) begin
        g.st = ST_FULL;
      end else begin
        id = HANDLE_W'(issued);
        issued++;
        block_rank[id] = CLASS_OUT_W'(rank);
        next_link[id]  = '0;
        busy[id]       = 1'b1;
        live_q.push_back(id);
        g.st  = ST_NEW;
        g.id  = id;
        g.cls = CLASS_OUT_W'(rank);
      end
    end else begin
      if (rq.hd >= issued) begin
        g.st = ST_UNKNOWN;
      end else if (!busy[rq.hd]) begin
        g.st = ST_DOUBLE;
      end else begin
        rank = block_rank[rq.hd];
        next_link[rq.hd] = list_top[rank];
        list_top[rank]   = rq.hd;
        list_len[rank]++;
        busy[rq.hd] = 1'b0;
        idx = -1;
        foreach (live_q[i]) if (live_q[i] == rq.hd) idx = i;
        if (idx >= 0) live_q.delete(idx);
        g.st  = ST_REUSED;
        g.cls = CLASS_OUT_W'(rank);
      end
    end
    return g;
  endfunction

  function automatic logic [SIZE_W-1:0] size_in_class(int r);
    longint unsigned hi, lo, pick;
    hi = 64'd1 << (MIN_SHIFT + r);
    lo = (r == 0) ? 64'd1 : (hi >> 1) + 64'd1;
    case ($urandom_range(0, 4))
      0:       pick = lo;
      1:       pick = hi;
      default: pick = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
    endcase
    return pick[SIZE_W-1:0];
  endfunction

  function automatic request_t alloc_request(int r);
    request_t rq;
    rq.req = REQ_ALLOC;
    rq.sz  = size_in_class(r);
    rq.hd  = HANDLE_W'($urandom);
    return rq;
  endfunction

  // Mostly well-formed traffic: allocate, free live blocks; some error noise.
  function automatic request_t random_request();
    request_t              rq;
    int                    choice;
    logic [63:0]           noise;
    logic [HANDLE_W-1:0]   pick;
    noise  = {$urandom, $urandom};
    choice = $urandom_range(0, 99);
    rq.req = REQ_FREE;
    rq.sz  = noise[SIZE_W-1:0];
    rq.hd  = HANDLE_W'($urandom);
    if (choice < 50) begin
      rq = alloc_request(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, NUM_CLASSES - 1));
    end else if (choice < 85 && live_q.size() != 0) begin
      rq.hd = live_q[$urandom_range(0, live_q.size() - 1)];
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          rq.req = REQ_ALLOC;
          rq.sz  = '0;
        end
        1: begin
          rq.req = REQ_ALLOC;
          rq.sz  = {1'b1, noise[SIZE_W-2:1], 1'b1};
        end
        2: ;
        3: if (issued < MAX_BLOCKS) rq.hd = HANDLE_W'($urandom_range(issued, MAX_BLOCKS - 1));
        default: begin
          // aim at a block that is already back on a free list
          for (int t = 0; t < 8 && issued != 0; t++) begin
            pick = HANDLE_W'($urandom_range(0, issued - 1));
            if (!busy[pick]) rq.hd = pick;
          end
        end
      endcase
    end
    return rq;
  endfunction

  task automatic send(input request_t rq, input bit typed, input grant_t typed_grant);
    grant_t g;
    int     gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq.req;
    size     <= rq.sz;
    handle   <= rq.hd;
    do @(posedge clk); while (!in_ready);
    g = predict_grant(rq);
    grants_due.push_back(typed ? typed_grant : g);
  endtask

  // Receiver: after each result, may drop ready; the hold counts down only while a result is pending.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b1;
      sink_hold <= 0;
    end else if (out_valid && out_ready) begin
      w = calm ? 0 : $urandom_range(0, 4);
      sink_hold <= w;
      out_ready <= (w == 0);
    end else if (!out_ready && out_valid) begin
      if (sink_hold <= 1) out_ready <= 1'b1;
      sink_hold <= sink_hold - 1;
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        $error("result with no request outstanding: status %0d block_id %0d size_class %0d",
               status, block_id, size_class);
        fails++;
      end else begin
        want = grants_due.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          fails++;
        end
        if (block_id !== want.id) begin
          $error("block_id: expected %0d, actual %0d", want.id, block_id);
          fails++;
        end
        if (size_class !== want.cls) begin
          $error("size_class: expected %0d, actual %0d", want.cls, size_class);
          fails++;
        end
      end
    end
  end

  initial begin
    request_t rq;
    grant_t   g;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      list_len[c] = 0;
      list_top[c] = '0;
    end
    foreach (busy[i]) busy[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      rq = '{plan[i].req, plan[i].sz, plan[i].hd};
      g  = '{plan[i].st, plan[i].id, plan[i].cls};
      send(rq, plan[i].typed, g);
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) calm <= ($urandom_range(0, 3) == 0);
      send(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fails == 0 && grants_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
